FILE: design/plc_pkg.sv
// Shared types, codes and defaults for the positional character list.
package plc_pkg;

    localparam int CAPACITY_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_GET   = 2'd2,
        CMD_PRINT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_POS = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_PRINT
    } t_state;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] position;
        logic [7:0] element;
    } t_in;

    typedef struct packed {
        logic [7:0] value;
        t_status    status;
        logic       last;
    } t_out;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic       ins;     // open a gap at idx and write elem there
        logic       del;     // close the gap at idx
        logic [7:0] idx;     // 0-based cell index of the edit
        logic [7:0] elem;
        logic [7:0] rd_idx;  // 0-based cell index to read
    } t_cell_ctl;

endpackage

FILE: design/plc_cell.sv
// One storage cell of the list: holds one element and shifts with its neighbors.
module plc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  plc_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]         i_left,
    input  logic [7:0]         i_right,
    output logic [7:0]         o_data,
    output logic [7:0]         o_rd
);
    import plc_pkg::*;

    logic [7:0] r_data;
    logic [7:0] n_data;
    logic       at_idx;
    logic       above_idx;

    assign at_idx    = (i_ctl.idx == 8'(CELL_IDX));
    assign above_idx = (8'(CELL_IDX) > i_ctl.idx);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (at_idx) begin
                n_data = i_ctl.elem;
            end else if (above_idx) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (at_idx || above_idx) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // drive the read bus only when addressed
    assign o_rd   = (i_ctl.rd_idx == 8'(CELL_IDX)) ? r_data : 8'd0;

endmodule

FILE: design/positional_char_list.sv
// Top level of the positional character list: controller, cell row and result register.
// Add, delete and get give their result in the cycle after the item is accepted.
// Throughput: one add, delete or get item per cycle while the result side keeps up.
// Print enters its streaming state, then streams one element per cycle while the result side keeps up
// (an empty list gets an empty status instead); no item is accepted until the last one is loaded.
// Reset (synchronous, active low) empties the list and drops any pending result;
// cell contents are not cleared, only cells below the count are ever read.
module positional_char_list #(
    parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  plc_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output plc_pkg::t_out o_out
);
    import plc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // Controller state
    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic        r_out_vld, n_out_vld;
    t_out        r_out, n_out;

    t_cell_ctl   ctl;
    logic [7:0]  cell_data [CAPACITY];
    logic [7:0]  cell_rd   [CAPACITY];
    logic [7:0]  rd_bus;

    logic        out_free;
    logic        in_acc;
    logic        out_load;
    logic        pos_zero;
    logic        add_bad;
    logic        rank_bad;
    logic        is_full;
    logic        ptr_last;

    // The result register is free when empty or being drained this cycle.
    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    // Range checks on the 1-based rank, done one bit wider than the position field.
    assign pos_zero = (i_in.position == 8'd0);
    assign add_bad  = pos_zero || ({1'b0, i_in.position} > (9'(r_count) + 9'd1));
    assign rank_bad = pos_zero || ({1'b0, i_in.position} > 9'(r_count));
    assign is_full  = (r_count == CW'(CAPACITY));
    assign ptr_last = ((r_ptr + CW'(1)) == r_count);

    // Read bus: each cell drives zero unless addressed, so OR them together.
    always_comb begin
        rd_bus = 8'd0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        out_load  = 1'b0;

        ctl.ins    = 1'b0;
        ctl.del    = 1'b0;
        ctl.idx    = i_in.position - 8'd1;
        ctl.elem   = i_in.element;
        ctl.rd_idx = (r_state == S_PRINT) ? 8'(r_ptr) : (i_in.position - 8'd1);

        // drain the result register
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    out_load     = 1'b1;
                    n_out.value  = 8'd0;
                    n_out.status = STS_OK;
                    n_out.last   = 1'b1;
                    unique case (i_in.command)
                        CMD_ADD: begin
                            if (add_bad) begin
                                n_out.status = STS_BAD_POS;
                            end else if (is_full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                ctl.ins = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_DEL: begin
                            if (rank_bad) begin
                                n_out.status = STS_BAD_POS;
                            end else begin
                                ctl.del = 1'b1;
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_GET: begin
                            if (rank_bad) begin
                                n_out.status = STS_BAD_POS;
                            end else begin
                                n_out.value = rd_bus;
                            end
                        end
                        CMD_PRINT: begin
                            if (r_count == '0) begin
                                n_out.status = STS_EMPTY;
                            end else begin
                                // stream from the S_PRINT state on
                                out_load = 1'b0;
                                n_ptr    = '0;
                                n_state  = S_PRINT;
                            end
                        end
                        default: begin
                            n_out.status = STS_BAD_POS;
                        end
                    endcase
                end
            end
            S_PRINT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out.value  = rd_bus;
                    n_out.status = STS_OK;
                    n_out.last   = ptr_last;
                    n_ptr        = r_ptr + CW'(1);
                    if (ptr_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_out_vld <= n_out_vld;
        end
    end

    // Result payload needs no reset; it is qualified by r_out_vld.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Row of cells: above the edit index a cell takes its left neighbor on insert; from it up, its right on delete.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  ((g == 0) ? 8'd0 : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? cell_data[g]
                                          : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (cell_data[g]),
            .o_rd    (cell_rd[g])
        );
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // The count never runs past the store.
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    // A print stream only runs over a non-empty list.
    a_print_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRINT) |-> (r_count != '0) && (r_ptr < r_count))
        else $error("print pointer outside the list");

    // Loading the final print element returns the controller to idle.
    a_print_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRINT && out_free && ptr_last) |=> (r_state == S_IDLE) && o_out.last)
        else $error("print stream did not end on its last element");

    // Count changes only on an accepted item.
    a_count_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_count))
        else $error("count changed without an accepted item");

endmodule
